// File: rtl/prefix_code_table_decoder_macros.svh
// ----------------------------------------------------------------------------
// Prefix code table decoder assertion macros
// Shared helpers that wrap clocked implication checks on aclk with reset.
// ----------------------------------------------------------------------------
`ifndef PREFIX_CODE_TABLE_DECODER_MACROS_SVH
`define PREFIX_CODE_TABLE_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCTD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pctd_pkg.sv
// ----------------------------------------------------------------------------
// Prefix code table decoder package
// Field widths, codes, defaults and the command and status types that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pctd_pkg;

    // Default sizes.
    localparam int DEF_MAX_ENTRIES  = 256;
    localparam int DEF_MAX_CODE_LEN = 15;

    // Decoding of one byte stops after this many results.
    localparam int MAX_RESULTS = 22;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    // Request field widths.
    localparam int MODE_W     = 2;
    localparam int IDX_IN_W   = 8;
    localparam int SYM_W      = 8;
    localparam int CODE_IN_W  = 15;
    localparam int LEN_IN_W   = 4;
    localparam int BYTE_W     = 8;
    localparam int S_FIELDS_W = IDX_IN_W + SYM_W + CODE_IN_W + LEN_IN_W + BYTE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = SYM_W;

    // Configuration register widths and APB geometry.
    localparam int ENTRY_COUNT_W = 9;
    localparam int PAD_W         = 3;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    // Register indexes (paddr[2]).
    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_PAD_BITS    = 1'b1;

    // Request kinds carried on s_tuser.
    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DATA    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

    // Controller to datapath.
    typedef struct packed {
        logic table_wr;   // write the table slot of the accepted request
        logic restart;    // clear the bit buffer, arm pad removal
        logic append;     // append the accepted data byte
        logic start;      // restart the table scan at slot zero
        logic search;     // scan one slot per cycle
        logic push;       // move the held result into the output register
        logic push_last;  // the pushed result closes the byte
        logic apply;      // consume the matched code or flush on a bad code
    } pctd_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic done;        // scan finished this cycle
        logic found;       // the finished scan matched an entry
        logic long_buf;    // at least a full code length is buffered
        logic apply_final; // consuming the match ends decoding of this byte
        logic hold_valid;  // a result waits in the hold register
        logic out_free;    // the output register can take a result
    } pctd_sts_t;

endpackage

// File: rtl/pctd_ctrl.sv
// ----------------------------------------------------------------------------
// Prefix code table decoder controller
// One-hot state machine that sequences load, restart and decode requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pctd_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [pctd_pkg::MODE_W-1:0] mode,
    input  pctd_pkg::pctd_sts_t         sts,
    output pctd_pkg::pctd_cmd_t         cmd
);
    import pctd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEARCH = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_APPLY  = 5'b01000,
        ST_FINAL  = 5'b10000
    } pctd_state_t;

    pctd_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (mode)
                        MODE_LOAD: begin
                            cmd.table_wr = 1'b1;
                        end
                        MODE_RESTART: begin
                            cmd.restart = 1'b1;
                        end
                        MODE_DATA: begin
                            cmd.append = 1'b1;
                            cmd.start  = 1'b1;
                            state_next = ST_SEARCH;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                cmd.search = 1'b1;
                if (sts.done) begin
                    state_next = sts.hold_valid ? ST_DRAIN : ST_APPLY;
                end
            end
            ST_DRAIN: begin
                // The held result closes the byte only if nothing follows it.
                cmd.push      = 1'b1;
                cmd.push_last = !(sts.found || sts.long_buf);
                if (sts.out_free) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                cmd.apply = 1'b1;
                if (sts.found) begin
                    if (sts.apply_final) begin
                        state_next = ST_FINAL;
                    end else begin
                        cmd.start  = 1'b1;
                        state_next = ST_SEARCH;
                    end
                end else if (sts.long_buf) begin
                    state_next = ST_FINAL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FINAL: begin
                cmd.push      = 1'b1;
                cmd.push_last = 1'b1;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/pctd_dp.sv
// ----------------------------------------------------------------------------
// Prefix code table decoder datapath
// Code table memory, bit buffer, slot scan and compare, result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pctd_dp #(
    parameter int MAX_ENTRIES  = pctd_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_CODE_LEN = pctd_pkg::DEF_MAX_CODE_LEN
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  pctd_pkg::pctd_cmd_t                cmd,
    output pctd_pkg::pctd_sts_t                sts,
    input  logic [pctd_pkg::ENTRY_COUNT_W-1:0] entry_count,
    input  logic [pctd_pkg::PAD_W-1:0]         pad_bits,
    input  logic [pctd_pkg::IDX_IN_W-1:0]      entry_index,
    input  logic [pctd_pkg::SYM_W-1:0]         entry_symbol,
    input  logic [pctd_pkg::CODE_IN_W-1:0]     entry_code,
    input  logic [pctd_pkg::LEN_IN_W-1:0]      entry_length,
    input  logic [pctd_pkg::BYTE_W-1:0]        data_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [pctd_pkg::SYM_W-1:0]         m_symbol,
    output logic                               m_bad_code,
    output logic                               m_last
);
    import pctd_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int LIM_W = (CNT_W > ENTRY_COUNT_W) ? CNT_W : ENTRY_COUNT_W;
    localparam int WIX_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;
    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
    localparam int BUF_W = MAX_CODE_LEN + BYTE_W - 1;
    localparam int BC_W  = $clog2(BUF_W + 1);
    localparam int ENT_W = LEN_W + MAX_CODE_LEN + SYM_W;

    // Table memory: {length, code, symbol} per slot.
    logic [ENT_W-1:0] table_mem [MAX_ENTRIES];
    logic [ENT_W-1:0] rdata_reg;

    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [BUF_W-1:0]  buf_reg, buf_next;
    logic [BC_W-1:0]   bcnt_reg, bcnt_next;
    logic              first_reg, first_next;
    logic [RES_W-1:0]  nres_reg, nres_next;
    logic              found_reg, found_next;
    logic              hold_vld_reg, hold_vld_next;
    logic              out_vld_reg, out_vld_next;
    logic [SYM_W-1:0]  fsym_reg;
    logic [LEN_W-1:0]  flen_reg;
    logic [SYM_W-1:0]  hold_sym_reg;
    logic              hold_bad_reg;
    logic [SYM_W-1:0]  out_sym_reg;
    logic              out_bad_reg;
    logic              out_last_reg;

    logic [CNT_W-1:0]        limit;
    logic                    rd_en;
    logic                    wr_en;
    logic [LEN_W-1:0]        r_len;
    logic [MAX_CODE_LEN-1:0] r_code;
    logic [SYM_W-1:0]        r_sym;
    logic [BC_W-1:0]         shamt;
    logic [BUF_W-1:0]        lead;
    logic [MAX_CODE_LEN-1:0] cmask;
    logic                    hit;
    logic                    done;
    logic [BC_W-1:0]         pad_sub;
    logic [BC_W-1:0]         app_cnt;
    logic [BUF_W-1:0]        app_buf;
    logic [BC_W-1:0]         rem_cnt;
    logic [BUF_W-1:0]        rem_buf;
    logic                    long_buf;
    logic                    out_free;
    logic                    load_out;

    // Scan limit: the slot count register saturates at the table depth.
    assign limit = (LIM_W'(entry_count) > LIM_W'(MAX_ENTRIES)) ?
                   CNT_W'(MAX_ENTRIES) : CNT_W'(entry_count);

    assign rd_en = cmd.search && (idx_reg < limit);
    assign wr_en = cmd.table_wr && (WIX_W'(entry_index) < WIX_W'(MAX_ENTRIES));

    assign r_len  = rdata_reg[ENT_W-1 -: LEN_W];
    assign r_code = rdata_reg[SYM_W +: MAX_CODE_LEN];
    assign r_sym  = rdata_reg[SYM_W-1:0];

    // Compare the entry against the leading r_len buffered bits.
    assign shamt = bcnt_reg - BC_W'(r_len);
    assign lead  = buf_reg >> shamt;
    assign cmask = ~({MAX_CODE_LEN{1'b1}} << r_len);
    assign hit   = (r_len != '0) && (BC_W'(r_len) <= bcnt_reg) &&
                   (((lead[MAX_CODE_LEN-1:0] ^ r_code) & cmask) == '0);

    // The scan ends on a match or once every slot has been compared.
    assign done = (cmp_vld_reg && hit) || (!cmp_vld_reg && (idx_reg >= limit));

    // Buffer stays below MAX_CODE_LEN bits between bytes, so a byte always fits.
    assign pad_sub = first_reg ? BC_W'(pad_bits) : '0;
    assign app_cnt = bcnt_reg + BC_W'(BYTE_W) - pad_sub;
    assign app_buf = {buf_reg[BUF_W-BYTE_W-1:0], data_byte} & ~({BUF_W{1'b1}} << app_cnt);

    assign rem_cnt = bcnt_reg - BC_W'(flen_reg);
    assign rem_buf = buf_reg & ~({BUF_W{1'b1}} << rem_cnt);

    assign long_buf = (bcnt_reg >= BC_W'(MAX_CODE_LEN));
    assign out_free = !out_vld_reg || m_ready;
    assign load_out = cmd.push && out_free;

    assign sts.done        = done;
    assign sts.found       = found_reg;
    assign sts.long_buf    = long_buf;
    assign sts.apply_final = (nres_reg == RES_W'(MAX_RESULTS - 1)) || (rem_cnt == '0);
    assign sts.hold_valid  = hold_vld_reg;
    assign sts.out_free    = out_free;

    always_comb begin
        idx_next      = idx_reg;
        cmp_vld_next  = cmp_vld_reg;
        buf_next      = buf_reg;
        bcnt_next     = bcnt_reg;
        first_next    = first_reg;
        nres_next     = nres_reg;
        found_next    = found_reg;
        hold_vld_next = hold_vld_reg;
        out_vld_next  = out_vld_reg;

        if (cmd.start) begin
            idx_next     = '0;
            cmp_vld_next = 1'b0;
        end else if (cmd.search) begin
            idx_next     = idx_reg + CNT_W'(rd_en);
            cmp_vld_next = rd_en;
        end

        if (cmd.search && done) begin
            found_next = cmp_vld_reg && hit;
        end

        if (cmd.restart) begin
            buf_next   = '0;
            bcnt_next  = '0;
            first_next = 1'b1;
        end else if (cmd.append) begin
            buf_next   = app_buf;
            bcnt_next  = app_cnt;
            first_next = 1'b0;
            nres_next  = '0;
        end else if (cmd.apply) begin
            if (found_reg) begin
                buf_next      = rem_buf;
                bcnt_next     = rem_cnt;
                nres_next     = nres_reg + RES_W'(1);
                hold_vld_next = 1'b1;
            end else if (long_buf) begin
                buf_next      = '0;
                bcnt_next     = '0;
                hold_vld_next = 1'b1;
            end
        end

        if (load_out) begin
            hold_vld_next = 1'b0;
            out_vld_next  = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            buf_reg      <= '0;
            bcnt_reg     <= '0;
            first_reg    <= 1'b1;
            nres_reg     <= '0;
            found_reg    <= 1'b0;
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            cmp_vld_reg  <= cmp_vld_next;
            buf_reg      <= buf_next;
            bcnt_reg     <= bcnt_next;
            first_reg    <= first_next;
            nres_reg     <= nres_next;
            found_reg    <= found_next;
            hold_vld_reg <= hold_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Code table: one write port for loads, one registered read port for the scan.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[entry_index[IDX_W-1:0]] <=
                {LEN_W'(entry_length), MAX_CODE_LEN'(entry_code), entry_symbol};
        end
        if (rd_en) begin
            rdata_reg <= table_mem[idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.search && done) begin
            fsym_reg <= r_sym;
            flen_reg <= r_len;
        end
        if (cmd.apply) begin
            hold_sym_reg <= found_reg ? fsym_reg : '0;
            hold_bad_reg <= !found_reg;
        end
        if (load_out) begin
            out_sym_reg  <= hold_sym_reg;
            out_bad_reg  <= hold_bad_reg;
            out_last_reg <= cmd.push_last;
        end
    end

    assign m_valid    = out_vld_reg;
    assign m_symbol   = out_sym_reg;
    assign m_bad_code = out_bad_reg;
    assign m_last     = out_last_reg;

endmodule

// File: rtl/prefix_code_table_decoder.sv
// ----------------------------------------------------------------------------
// Prefix code table decoder
// Decodes a prefix-coded byte stream through a loaded table of codes.
// ----------------------------------------------------------------------------
// A request on the input stream either loads one table slot (symbol, code of
// up to MAX_CODE_LEN bits, length), restarts the stream, or delivers one data
// byte. Load and restart requests produce nothing. A data
// byte is appended MSB first to the bit buffer (after dropping pad_bits top
// bits on the first byte of a stream) and then decoded: the table is scanned
// in slot order for the first entry whose code equals the leading buffered
// bits, its symbol is sent and its bits are consumed, and the scan starts
// over. When no entry matches and MAX_CODE_LEN or more bits are buffered, the
// buffer is flushed and a result with bad_code set and symbol zero is sent.
// A byte yields up to 22 results; the last one carries tlast. The scan reads
// one slot per cycle from the single read port of the table memory. A new
// request is taken once the byte is fully decoded, even while its final
// result still waits in the output register. The table has no reset;
// entries must be loaded before a scan reaches them. Configuration
// (entry_count at 0x0, pad_bits at 0x4) may only change while the block is
// idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "prefix_code_table_decoder_macros.svh"

module prefix_code_table_decoder #(
    parameter int MAX_ENTRIES  = pctd_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_CODE_LEN = pctd_pkg::DEF_MAX_CODE_LEN
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // From bit 0: entry_index[7:0], entry_symbol[15:8], entry_code[30:16],
    // entry_length[34:31], data_byte[42:35], zero fill[47:43].
    input  logic [pctd_pkg::S_TDATA_W-1:0]  s_tdata,
    // mode[1:0]: 0 load table slot, 1 data byte, 2 restart stream.
    input  logic [pctd_pkg::MODE_W-1:0]     s_tuser,

    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // symbol[7:0].
    output logic [pctd_pkg::M_TDATA_W-1:0]  m_tdata,
    // bad_code[0].
    output logic                            m_tuser,
    output logic                            m_tlast,

    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pctd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pctd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pctd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import pctd_pkg::*;

    localparam int OFS_SYM  = IDX_IN_W;
    localparam int OFS_CODE = OFS_SYM + SYM_W;
    localparam int OFS_LEN  = OFS_CODE + CODE_IN_W;
    localparam int OFS_BYTE = OFS_LEN + LEN_IN_W;

    logic [ENTRY_COUNT_W-1:0] entry_count_reg, entry_count_next;
    logic [PAD_W-1:0]         pad_bits_reg, pad_bits_next;
    logic                     cfg_wr;
    logic                     reg_sel;

    pctd_cmd_t cmd;
    pctd_sts_t sts;

    // Configuration registers: written on the access cycle of a write.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_comb begin
        entry_count_next = entry_count_reg;
        pad_bits_next    = pad_bits_reg;
        if (cfg_wr) begin
            case (reg_sel)
                REG_ENTRY_COUNT: entry_count_next = pwdata[ENTRY_COUNT_W-1:0];
                REG_PAD_BITS:    pad_bits_next    = pwdata[PAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_ENTRY_COUNT: prdata = APB_DATA_W'(entry_count_reg);
            REG_PAD_BITS:    prdata = APB_DATA_W'(pad_bits_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            pad_bits_reg    <= '0;
        end else begin
            entry_count_reg <= entry_count_next;
            pad_bits_reg    <= pad_bits_next;
        end
    end

    // Sequencing of requests and decode steps.
    pctd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Table, bit buffer, scan and result registers.
    pctd_dp #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .entry_count  (entry_count_reg),
        .pad_bits     (pad_bits_reg),
        .entry_index  (s_tdata[IDX_IN_W-1:0]),
        .entry_symbol (s_tdata[OFS_SYM +: SYM_W]),
        .entry_code   (s_tdata[OFS_CODE +: CODE_IN_W]),
        .entry_length (s_tdata[OFS_LEN +: LEN_IN_W]),
        .data_byte    (s_tdata[OFS_BYTE +: BYTE_W]),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_symbol     (m_tdata),
        .m_bad_code   (m_tuser),
        .m_last       (m_tlast)
    );

    // A bad-code result never carries a symbol.
    `PCTD_ASSERT_IMP(a_bad_sym_zero, m_tvalid && m_tuser, m_tdata == '0, "bad code with symbol")
    // A new request is taken only when no decoded result is held back.
    `PCTD_ASSERT_IMP(a_idle_no_hold, s_tready, !sts.hold_valid, "request taken with held result")
    // Accepting a data byte starts decoding, so the input stalls next cycle.
    `PCTD_ASSERT_NEXT(a_byte_busy, s_tvalid && s_tready && (s_tuser == MODE_DATA),
                      !s_tready, "input open during decode")

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Prefix code table decoder testbench
// Loads code tables, streams bytes and checks every decoded symbol in order.
// ----------------------------------------------------------------------------
// The testbench drives the request stream and the configuration port with
// plain tasks. A small scoreboard class keeps its own copy of the code table,
// the bit buffer and the two registers. For each accepted request it works
// out the decoded symbols, and it compares each accepted result with the
// oldest one still waiting.
//
// A short directed part comes first. It covers an ignored request kind, a bad
// code with an empty table, pad removal at both ends of its range, a zero
// length entry, code bits above the entry length, an entry longer than the
// buffered bits and a byte that reaches the per-byte result limit.
//
// The random part builds prefix codes by splitting random leaves of a binary
// tree, and loads them with random fill above each code. Now and then a slot
// gets junk instead, which leaves the code incomplete or overlapping. Each
// table is followed by a stream of random bytes, mixed with restarts, table
// rewrites, ignored requests and drains. A last phase uses all 256 slots,
// first with entry_count at 256 and then with a value that saturates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import pctd_pkg::*;

    // Request kind that the block ignores.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Field positions in s_tdata.
    localparam int IDX_LSB  = 0;
    localparam int SYM_LSB  = IDX_LSB + IDX_IN_W;
    localparam int CODE_LSB = SYM_LSB + SYM_W;
    localparam int LEN_LSB  = CODE_LSB + CODE_IN_W;
    localparam int BYTE_LSB = LEN_LSB + LEN_IN_W;

    // A byte that may not fit into the buffer first clears it.
    localparam int BUFFER_LIMIT = 31;

    // Long enough for a scan that finds nothing to finish, with room to spare.
    localparam int SCAN_SETTLE     = DEF_MAX_ENTRIES + 40;
    localparam int WATCHDOG_LIMIT  = 5000;
    // The directed part and the full-table phase add close to 300 requests.
    localparam int RANDOM_REQUESTS = 30;

    typedef struct packed {
        bit [SYM_W-1:0] symbol;
        bit             bad_code;
        bit             last;
    } decoded_symbol_t;

    // Keeps a private copy of the decoder state and the symbols it owes.
    class symbol_scoreboard;
        bit [SYM_W-1:0]     slot_symbol [DEF_MAX_ENTRIES];
        bit [CODE_IN_W-1:0] slot_code   [DEF_MAX_ENTRIES];
        bit [LEN_IN_W-1:0]  slot_length [DEF_MAX_ENTRIES];
        bit [63:0]          bit_buf;
        int unsigned        bit_cnt;
        bit                 first_pending = 1'b1;
        bit [ENTRY_COUNT_W-1:0] entries_searched;
        bit [PAD_W-1:0]     pad_bits;
        decoded_symbol_t    expected_symbols[$];
        int                 mismatches;

        function bit [63:0] low_mask(int unsigned n);
            return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        endfunction

        function int outstanding();
            return expected_symbols.size();
        endfunction

        function void note_register(logic reg_sel, logic [APB_DATA_W-1:0] value);
            if (reg_sel == REG_ENTRY_COUNT)
                entries_searched = value[ENTRY_COUNT_W-1:0];
            else
                pad_bits = value[PAD_W-1:0];
        endfunction

        // First slot, in slot order, whose code equals the leading bits.
        function int find_match();
            int unsigned span;
            int unsigned len;
            span = (entries_searched > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : entries_searched;
            for (int i = 0; i < span; i++) begin
                len = slot_length[i];
                if (len == 0 || len > bit_cnt)
                    continue;
                if (((bit_buf >> (bit_cnt - len)) & low_mask(len)) ==
                    (64'(slot_code[i]) & low_mask(len)))
                    return i;
            end
            return -1;
        endfunction

        function void decode_byte(bit [BYTE_W-1:0] data);
            decoded_symbol_t produced[$];
            int hit;
            if (bit_cnt + BYTE_W > BUFFER_LIMIT) begin
                bit_buf = '0;
                bit_cnt = 0;
            end
            bit_buf = (bit_buf << BYTE_W) | 64'(data);
            bit_cnt += BYTE_W;
            if (first_pending) begin
                bit_cnt -= pad_bits;
                first_pending = 1'b0;
            end
            bit_buf &= low_mask(bit_cnt);
            while (produced.size() < MAX_RESULTS && bit_cnt > 0) begin
                hit = find_match();
                if (hit >= 0) begin
                    produced.push_back('{symbol: slot_symbol[hit], bad_code: 1'b0, last: 1'b0});
                    bit_cnt -= slot_length[hit];
                    bit_buf &= low_mask(bit_cnt);
                end else begin
                    // Nothing can match any more once a full code length is
                    // buffered, so the whole buffer is thrown away.
                    if (bit_cnt >= DEF_MAX_CODE_LEN) begin
                        produced.push_back('{symbol: '0, bad_code: 1'b1, last: 1'b0});
                        bit_buf = '0;
                        bit_cnt = 0;
                    end
                    break;
                end
            end
            if (produced.size() > 0)
                produced[produced.size() - 1].last = 1'b1;
            foreach (produced[i])
                expected_symbols.push_back(produced[i]);
        endfunction

        function void note_request(logic [MODE_W-1:0] kind, logic [S_TDATA_W-1:0] fields);
            int unsigned idx;
            idx = fields[IDX_LSB +: IDX_IN_W];
            case (kind)
                MODE_LOAD: begin
                    slot_symbol[idx] = fields[SYM_LSB +: SYM_W];
                    slot_code[idx]   = fields[CODE_LSB +: CODE_IN_W];
                    slot_length[idx] = fields[LEN_LSB +: LEN_IN_W];
                end
                MODE_DATA: begin
                    decode_byte(fields[BYTE_LSB +: BYTE_W]);
                end
                MODE_RESTART: begin
                    bit_buf = '0;
                    bit_cnt = 0;
                    first_pending = 1'b1;
                end
                default: begin
                end
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_result(logic [SYM_W-1:0] symbol, logic bad_code, logic last);
            decoded_symbol_t want;
            if (expected_symbols.size() == 0) begin
                report_mismatch($sformatf("result %02h bad_code %b last %b with none expected",
                                          symbol, bad_code, last));
                return;
            end
            want = expected_symbols.pop_front();
            if (symbol !== want.symbol)
                report_mismatch($sformatf("symbol %02h, expected %02h", symbol, want.symbol));
            if (bad_code !== want.bad_code)
                report_mismatch($sformatf("bad_code %b, expected %b", bad_code, want.bad_code));
            if (last !== want.last)
                report_mismatch($sformatf("last %b, expected %b", last, want.last));
        endtask
    endclass

    // Every input of the block starts at a known value.
    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [MODE_W-1:0]      s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    symbol_scoreboard symbols;

    // Sender pacing: requests go out in bursts, with gaps between them unless
    // the current phase runs without idling.
    int burst_left    = 0;
    bit sender_steady = 1'b0;
    int requests_sent = 0;
    int idle_cycles   = 0;

    // Receiver pacing: a 16-bit stall pattern, redrawn whenever ready_phase wraps.
    bit [15:0] stall_pattern = '1;
    bit [7:0]  ready_phase   = '0;

    prefix_code_table_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if (ready_phase == 8'd0) begin
            // One pattern in four never stalls; the others keep bit 0 set, so each pass
            // through the pattern always lets at least one result through.
            if ($urandom_range(0, 3) == 0)
                stall_pattern <= '1;
            else
                stall_pattern <= 16'($urandom) | 16'h0001;
        end
        ready_phase <= ready_phase + 8'd1;
        m_tready    <= stall_pattern[ready_phase[3:0]];
    end

    // Results are sampled at the edge where they are accepted.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            symbols.check_result(m_tdata, m_tuser, m_tlast);
    end

    // The run ends if neither side moves and the configuration port is quiet
    // for far longer than a full table scan plus a receiver stall.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one request and returns at the edge where it is accepted.
    task automatic send_request(input logic [MODE_W-1:0] kind, input logic [IDX_IN_W-1:0] idx,
                                input logic [SYM_W-1:0] sym, input logic [CODE_IN_W-1:0] code,
                                input logic [LEN_IN_W-1:0] len, input logic [BYTE_W-1:0] data);
        logic [S_TDATA_W-1:0] fields;
        int gap;
        fields = '0;
        fields[IDX_LSB +: IDX_IN_W]   = idx;
        fields[SYM_LSB +: SYM_W]      = sym;
        fields[CODE_LSB +: CODE_IN_W] = code;
        fields[LEN_LSB +: LEN_IN_W]   = len;
        fields[BYTE_LSB +: BYTE_W]    = data;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (!sender_steady && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= fields;
        do @(posedge aclk); while (!s_tready);
        symbols.note_request(kind, fields);
        if (kind != MODE_UNUSED)
            requests_sent++;
    endtask

    // The fields that a request kind does not use carry random values, so
    // the block is seen to ignore them.
    task automatic load_slot(input logic [IDX_IN_W-1:0] idx, input logic [SYM_W-1:0] sym,
                             input logic [CODE_IN_W-1:0] code, input logic [LEN_IN_W-1:0] len);
        send_request(MODE_LOAD, idx, sym, code, len, 8'($urandom));
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] data);
        send_request(MODE_DATA, 8'($urandom), 8'($urandom), 15'($urandom), 4'($urandom), data);
    endtask

    task automatic restart_stream();
        send_request(MODE_RESTART, 8'($urandom), 8'($urandom), 15'($urandom), 4'($urandom),
                     8'($urandom));
    endtask

    // Stops sending, waits for every owed result, then lets a byte that
    // produced nothing finish its scan.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (symbols.outstanding() != 0) @(posedge aclk);
        repeat (SCAN_SETTLE) @(posedge aclk);
    endtask

    // Setup phase, access phase, then the port goes quiet before the next write.
    task automatic write_register(input logic reg_sel, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        symbols.note_register(reg_sel, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_decoder(input logic [PAD_W-1:0] pad,
                               input logic [ENTRY_COUNT_W-1:0] entries);
        settle_block();
        write_register(REG_ENTRY_COUNT, APB_DATA_W'(entries));
        write_register(REG_PAD_BITS, APB_DATA_W'(pad));
    endtask

    // Grows a complete prefix code with the given number of leaves by
    // splitting random leaves, then loads the leaves into slots 0 upward in
    // random order. The bits above each code length are random. About one
    // slot in eight gets a random entry instead, which can shadow others or
    // leave holes in the code.
    task automatic load_prefix_code(input int leaves);
        bit [CODE_IN_W-1:0] leaf_code[$];
        int                 leaf_len[$];
        bit [CODE_IN_W-1:0] code;
        int                 len;
        int                 pick;
        leaf_code.push_back('0);
        leaf_len.push_back(0);
        while (leaf_code.size() < leaves) begin
            do pick = $urandom_range(0, leaf_code.size() - 1);
            while (leaf_len[pick] >= DEF_MAX_CODE_LEN);
            code = leaf_code[pick];
            len  = leaf_len[pick];
            leaf_code.delete(pick);
            leaf_len.delete(pick);
            leaf_code.push_back({code[CODE_IN_W-2:0], 1'b0});
            leaf_len.push_back(len + 1);
            leaf_code.push_back({code[CODE_IN_W-2:0], 1'b1});
            leaf_len.push_back(len + 1);
        end
        for (int slot = 0; slot < leaves; slot++) begin
            pick = $urandom_range(0, leaf_code.size() - 1);
            code = leaf_code[pick];
            len  = leaf_len[pick];
            leaf_code.delete(pick);
            leaf_len.delete(pick);
            if ($urandom_range(0, 7) == 0) begin
                code = 15'($urandom);
                len  = $urandom_range(0, DEF_MAX_CODE_LEN);
            end else begin
                code = code | (15'($urandom) & ~15'((1 << len) - 1));
            end
            load_slot(8'(slot), 8'($urandom), code, 4'(len));
        end
    endtask

    initial begin
        int directed_end;
        int entries;
        symbols = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // An unused request kind with every field bit set must change nothing.
        send_request(MODE_UNUSED, '1, '1, '1, '1, '1);

        // With an empty table the second byte leaves 16 bits that cannot
        // match, so the buffer is flushed with a bad code.
        send_byte(8'hFF);
        send_byte(8'h00);

        // Two pad bits drop off the first byte, leaving 14 bits that wait.
        set_decoder(3'd2, 9'd0);
        restart_stream();
        send_byte(8'hFF);
        send_byte(8'hFF);

        // One-bit codes for both values: the next byte makes 22 bits, each
        // decoded on its own, which is exactly the per-byte result limit.
        // The stored code of the first slot has fill above its length.
        load_slot(8'd0, 8'h00, 15'h7FFF, 4'd1);
        load_slot(8'd1, 8'hFF, 15'h0000, 4'd1);
        set_decoder(3'd2, 9'd2);
        send_byte(8'h55);

        // A zero length entry ahead of the others never matches, a 15-bit
        // code waits until 15 bits are buffered, and seven pad bits leave a
        // single bit from the first byte.
        load_slot(8'd0, 8'h11, 15'h1234, 4'd0);
        load_slot(8'd1, 8'h22, 15'h7FFD, 4'd3);
        load_slot(8'd2, 8'h33, 15'h7FFF, 4'd15);
        load_slot(8'd3, 8'h44, 15'h2AAA, 4'd1);
        set_decoder(3'd7, 9'd4);
        restart_stream();
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA0);
        send_byte(8'h50);

        // Random phases: a fresh small table, a new pad width, and a stream
        // of bytes with occasional disturbances.
        directed_end = requests_sent;
        while (requests_sent < directed_end + RANDOM_REQUESTS) begin
            entries = $urandom_range(2, 24);
            sender_steady = ($urandom_range(0, 3) == 0);
            set_decoder(3'($urandom_range(0, 7)), 9'(entries));
            load_prefix_code(entries);
            if ($urandom_range(0, 5) != 0)
                restart_stream();
            repeat ($urandom_range(4, 20)) begin
                case ($urandom_range(0, 19))
                    0: send_request(MODE_UNUSED, 8'($urandom), 8'($urandom), 15'($urandom),
                                    4'($urandom), 8'($urandom));
                    1: restart_stream();
                    2: load_slot(8'($urandom_range(0, entries - 1)), 8'($urandom),
                                 15'($urandom), 4'($urandom));
                    3: settle_block();
                    default: begin
                    end
                endcase
                send_byte(8'($urandom));
            end
        end

        // Full table: every slot is searched, first with entry_count at the
        // table size and then with a count beyond it, which saturates.
        sender_steady = 1'b0;
        set_decoder(3'($urandom_range(0, 7)), 9'(DEF_MAX_ENTRIES));
        load_prefix_code(DEF_MAX_ENTRIES);
        restart_stream();
        repeat (10) send_byte(8'($urandom));
        set_decoder(3'd0, 9'h1FF);
        repeat (10) send_byte(8'($urandom));

        settle_block();
        if (symbols.mismatches == 0 && symbols.outstanding() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
